// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ray/sphere intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
// Shared widths, register codes and pipeline side-band types.
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int FRAC_W   = 16;
  // square root unit: 72-bit radicand, 36-bit root, one root bit per stage
  localparam int SQ_IN_W  = 72;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 3;
  // magnitude of hit point minus centre
  localparam int A_W      = 43;
  // the largest normalised normal magnitude lies in [2^29, 2^30)
  localparam int NA_W     = 30;
  localparam int LEN_W    = 31;
  // divider: quotient below 2^17, one quotient bit per stage
  localparam int DV_Q_W   = 17;
  localparam int DV_REM_W = NA_W + FRAC_W;
  localparam int DV_CMP_W = DV_REM_W + 2;

  localparam logic [DV_Q_W-1:0] NORM_ONE = DV_Q_W'(65536);
  localparam logic [30:0]       MAX_DIST = 31'h7fff_ffff;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  typedef struct packed {
    logic               miss;
    logic               sos;
    logic signed [36:0] b;
    logic [2:0][31:0]   o;
    logic [2:0][17:0]   d;
  } rsi_ray_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      dst;
    logic [2:0][31:0] pt;
    logic [2:0]       neg;
    logic             nz;
  } rsi_res_t;

  typedef struct packed {
    rsi_res_t               res;
    logic [2:0][NA_W-1:0]   a;
  } rsi_nrm_t;

endpackage

// ===== rtl/ray_sphere_intersect_core.sv =====
// Ray/sphere intersection core: config registers, arithmetic pipeline, output stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   Input channel in_*: one ray per item (origin, unit direction in Q16.16,
//   starts-on-sphere flag). Output channel out_*: one result item per ray
//   (hit, distance, hit point, unit normal; all zero on a miss).
//   Sphere centre and radius sit in APB registers at byte offsets 0, 4, 8, 12;
//   write them only while no item is in flight.
// Timing
//   Fully pipelined: one item per clock is accepted and delivered while no output item waits under out_stall.
//   The pipeline has 5 front stages (offset, dot product, squares,
//   discriminant), a 36-stage square root, 8 stages for root choice, hit
//   point and normal scaling, a second 36-stage square root for the normal
//   length, a 17-stage divider and the output register.
// Reset and stall
//   rst_n clears all pipeline valid bits and loads centre 0, radius 1.0.
//   While an output item waits under out_stall the whole pipeline holds and
//   in_stall is raised; no item is dropped or duplicated.
module ray_sphere_intersect_core import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  input  logic               in_starts_on_sphere,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [30:0]        out_distance,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- configuration ----------------
  logic signed [31:0] ctr_x_r, ctr_y_r, ctr_z_r;
  logic [30:0]        rad_cfg_r;
  logic               cfg_wr;
  logic signed [31:0] c [3];

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign c[0]   = ctr_x_r;
  assign c[1]   = ctr_y_r;
  assign c[2]   = ctr_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_x_r   <= '0;
      ctr_y_r   <= '0;
      ctr_z_r   <= '0;
      rad_cfg_r <= 31'd65536;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CENTER_X: ctr_x_r   <= pwdata;
        REG_CENTER_Y: ctr_y_r   <= pwdata;
        REG_CENTER_Z: ctr_z_r   <= pwdata;
        REG_RADIUS:   rad_cfg_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTER_X: prdata = ctr_x_r;
      REG_CENTER_Y: prdata = ctr_y_r;
      REG_CENTER_Z: prdata = ctr_z_r;
      REG_RADIUS:   prdata = {1'b0, rad_cfg_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic adv;
  logic out_valid_r;
  logic [4:0]          fv_r;
  logic [SQ_OUT_W-1:0] sv1_r, sv2_r;
  logic [7:0]          bv_r;
  logic [DV_Q_W-1:0]   dvv_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      sv1_r       <= '0;
      bv_r        <= '0;
      sv2_r       <= '0;
      dvv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fv_r        <= {fv_r[3:0], in_valid};
      sv1_r       <= {sv1_r[SQ_OUT_W-2:0], fv_r[4]};
      bv_r        <= {bv_r[6:0], sv1_r[SQ_OUT_W-1]};
      sv2_r       <= {sv2_r[SQ_OUT_W-2:0], bv_r[7]};
      dvv_r       <= {dvv_r[DV_Q_W-2:0], sv2_r[SQ_OUT_W-1]};
      out_valid_r <= dvv_r[DV_Q_W-1];
    end
  end

  // ---------------- front: offset, dot product, discriminant ----------------
  rsi_ray_t ray_in, ray1_r, ray2_r, ray3_r, ray4_r, ray5_r;
  rsi_ray_t ray3_nxt, ray5_nxt;
  logic signed [32:0] m1_r  [3];
  logic [32:0]        mm1   [3];
  logic signed [50:0] p2_r  [3];
  logic [65:0]        sq2_r [3];
  logic [61:0]        r2_2_r, r2_3_r, r2_4_r;
  logic signed [52:0] bsum;
  logic [67:0]        mm3_r, mm4_r;
  logic [35:0]        bmag;
  logic [71:0]        b2_4_r, lhs, disc5_r;
  logic               miss_c;

  always_comb begin
    ray_in.miss = 1'b0;
    ray_in.sos  = in_starts_on_sphere;
    ray_in.b    = '0;
    ray_in.o[0] = in_origin_x;
    ray_in.o[1] = in_origin_y;
    ray_in.o[2] = in_origin_z;
    ray_in.d[0] = in_dir_x;
    ray_in.d[1] = in_dir_y;
    ray_in.d[2] = in_dir_z;
    for (int i = 0; i < 3; i++) begin
      mm1[i] = m1_r[i][32] ? 33'(-m1_r[i]) : 33'(m1_r[i]);
    end
    bsum = p2_r[0] + p2_r[1] + p2_r[2];
    ray3_nxt   = ray2_r;
    ray3_nxt.b = bsum[52:FRAC_W];
    bmag = ray3_r.b[36] ? 36'(-ray3_r.b) : 36'(ray3_r.b);
    lhs    = b2_4_r + 72'(r2_4_r);
    miss_c = 72'(mm4_r) > lhs;
    ray5_nxt      = ray4_r;
    ray5_nxt.miss = miss_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray1_r <= ray_in;
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= {ray_in.o[i][31], ray_in.o[i]} - {c[i][31], c[i]};
        p2_r[i]  <= $signed(ray1_r.d[i]) * m1_r[i];
        sq2_r[i] <= mm1[i] * mm1[i];
      end
      ray2_r   <= ray1_r;
      r2_2_r   <= rad_cfg_r * rad_cfg_r;
      ray3_r   <= ray3_nxt;
      mm3_r    <= 68'(sq2_r[0]) + 68'(sq2_r[1]) + 68'(sq2_r[2]);
      r2_3_r   <= r2_2_r;
      ray4_r   <= ray3_r;
      b2_4_r   <= bmag * bmag;
      mm4_r    <= mm3_r;
      r2_4_r   <= r2_3_r;
      ray5_r      <= ray5_nxt;
      disc5_r     <= lhs - 72'(mm4_r);
    end
  end

  // ---------------- square root of the discriminant ----------------
  logic [SQ_OUT_W-1:0] root1;
  rsi_ray_t            ray_dl [SQ_OUT_W];
  rsi_ray_t            rd;

  rsi_sqrt u_sqrt_disc (
    .clk  (clk),
    .en   (adv),
    .rad  (disc5_r),
    .root (root1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ray_dl[0] <= ray5_r;
      for (int j = 1; j < SQ_OUT_W; j++) ray_dl[j] <= ray_dl[j-1];
    end
  end

  assign rd = ray_dl[SQ_OUT_W-1];

  // ---------------- root choice, hit point, normal scaling ----------------
  logic signed [38:0] bx, sx, tn, tf, t_c;
  logic [38:0]        atn, atf;
  logic               miss6;
  logic               hit6_r, hit7_r, hit8_r;
  logic signed [38:0] t6_r;
  logic [2:0][31:0]   o6_r, o7_r;
  logic [2:0][17:0]   d6_r;
  logic [30:0]        dist7_r, dist8_r;
  logic signed [56:0] dt7_r [3];
  logic signed [41:0] hp8_r [3];
  logic signed [42:0] n9    [3];
  rsi_res_t           res9_c, res9_r, res10_r, res11_r, res12_r, res13_r;
  rsi_res_t           res10_nxt;
  logic [A_W-1:0]     a9_r  [3];
  logic [A_W-1:0]     a10_r [3];
  logic [A_W-1:0]     a_or;
  logic [5:0]         pos_c, pos10_r;
  logic [A_W-1:0]     a_sh  [3];
  logic [2:0][NA_W-1:0] a11_r, a12_r, a13_r;
  logic [2*NA_W-1:0]  sq12_r [3];
  logic [61:0]        l2_13_r;

  always_comb begin
    bx  = {{2{rd.b[36]}}, rd.b};
    sx  = {3'b000, root1};
    tn  = -bx - sx;
    tf  = -bx + sx;
    atn = tn[38] ? -tn : tn;
    atf = tf[38] ? -tf : tf;
    if (rd.sos) begin
      // ray leaving the surface: far root only when the near one is not farther
      miss6 = atn > atf;
      t_c   = tf;
    end else begin
      miss6 = 1'b0;
      t_c   = tn[38] ? tf : tn;
    end
    miss6 = miss6 | t_c[38];

    res9_c.hit  = hit8_r;
    res9_c.dst  = dist8_r;
    res9_c.nz   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      n9[i] = {hp8_r[i][41], hp8_r[i]} - {{11{c[i][31]}}, c[i]};
      res9_c.neg[i] = n9[i][42];
      if (hp8_r[i] > 42'sd2147483647)        res9_c.pt[i] = 32'h7fff_ffff;
      else if (hp8_r[i] < -42'sd2147483648)  res9_c.pt[i] = 32'h8000_0000;
      else                                   res9_c.pt[i] = hp8_r[i][31:0];
    end

    a_or  = a9_r[0] | a9_r[1] | a9_r[2];
    pos_c = '0;
    for (int k = 0; k < A_W; k++) begin
      if (a_or[k]) pos_c = 6'(k);
    end
    res10_nxt    = res9_r;
    res10_nxt.nz = (a_or == '0);

    // bring the largest magnitude into [2^29, 2^30); right shifts truncate
    for (int i = 0; i < 3; i++) begin
      if (pos10_r >= 6'(NA_W - 1)) a_sh[i] = a10_r[i] >> (pos10_r - 6'(NA_W - 1));
      else                         a_sh[i] = a10_r[i] << (6'(NA_W - 1) - pos10_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit6_r <= !rd.miss && !miss6;
      t6_r   <= t_c;
      o6_r   <= rd.o;
      d6_r   <= rd.d;

      hit7_r  <= hit6_r;
      dist7_r <= (t6_r > 39'sd2147483647) ? MAX_DIST : t6_r[30:0];
      o7_r    <= o6_r;
      for (int i = 0; i < 3; i++) dt7_r[i] <= $signed(d6_r[i]) * t6_r;

      hit8_r  <= hit7_r;
      dist8_r <= dist7_r;
      for (int i = 0; i < 3; i++) begin
        hp8_r[i] <= {{10{o7_r[i][31]}}, o7_r[i]} + {dt7_r[i][56], dt7_r[i][56:FRAC_W]};
      end

      res9_r <= res9_c;
      for (int i = 0; i < 3; i++) a9_r[i] <= n9[i][42] ? A_W'(-n9[i]) : A_W'(n9[i]);

      res10_r    <= res10_nxt;
      pos10_r    <= pos_c;
      for (int i = 0; i < 3; i++) a10_r[i] <= a9_r[i];

      res11_r <= res10_r;
      for (int i = 0; i < 3; i++) a11_r[i] <= a_sh[i][NA_W-1:0];

      res12_r <= res11_r;
      a12_r   <= a11_r;
      for (int i = 0; i < 3; i++) sq12_r[i] <= a11_r[i] * a11_r[i];

      res13_r <= res12_r;
      a13_r   <= a12_r;
      l2_13_r <= 62'(sq12_r[0]) + 62'(sq12_r[1]) + 62'(sq12_r[2]);
    end
  end

  // ---------------- normal length ----------------
  logic [SQ_OUT_W-1:0] root2;
  rsi_nrm_t            nrm_in;
  rsi_nrm_t            nrm_dl [SQ_OUT_W];
  rsi_nrm_t            nd;

  assign nrm_in.res = res13_r;
  assign nrm_in.a   = a13_r;

  rsi_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (adv),
    .rad  (SQ_IN_W'(l2_13_r)),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm_dl[0] <= nrm_in;
      for (int j = 1; j < SQ_OUT_W; j++) nrm_dl[j] <= nrm_dl[j-1];
    end
  end

  assign nd = nrm_dl[SQ_OUT_W-1];

  // ---------------- component division ----------------
  logic [DV_Q_W-1:0] quo [3];
  rsi_res_t          res_dl [DV_Q_W];
  rsi_res_t          rf;

  for (genvar i = 0; i < 3; i++) begin : g_div
    rsi_div u_div (
      .clk (clk),
      .en  (adv),
      .num (nd.a[i]),
      .den (root2[LEN_W-1:0]),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_dl[0] <= nd.res;
      for (int j = 1; j < DV_Q_W; j++) res_dl[j] <= res_dl[j-1];
    end
  end

  assign rf = res_dl[DV_Q_W-1];

  // ---------------- output register ----------------
  logic [DV_Q_W-1:0]  qc  [3];
  logic signed [17:0] nrm [3];
  logic               out_hit_r;
  logic [30:0]        out_distance_r;
  logic signed [31:0] out_point_r  [3];
  logic signed [17:0] out_normal_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i]  = (quo[i] > NORM_ONE) ? NORM_ONE : quo[i];
      nrm[i] = rf.neg[i] ? -18'(qc[i]) : 18'(qc[i]);
      if (!rf.hit || rf.nz) nrm[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r      <= rf.hit;
      out_distance_r <= rf.hit ? rf.dst : '0;
      for (int i = 0; i < 3; i++) begin
        out_point_r[i]  <= rf.hit ? rf.pt[i] : '0;
        out_normal_r[i] <= nrm[i];
      end
    end
  end

  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;
  assign out_point_x  = out_point_r[0];
  assign out_point_y  = out_point_r[1];
  assign out_point_z  = out_point_r[2];
  assign out_normal_x = out_normal_r[0];
  assign out_normal_y = out_normal_r[1];
  assign out_normal_z = out_normal_r[2];

  // ---------------- checks ----------------
  logic miss_payload_zero, normal_in_range;

  assign miss_payload_zero = out_distance_r == '0 && out_point_r[0] == '0 &&
                             out_normal_r[0] == '0 && out_normal_r[2] == '0;
  assign normal_in_range   = out_normal_r[0] <= 18'sd65536 && out_normal_r[0] >= -18'sd65536 &&
                             out_normal_r[1] <= 18'sd65536 && out_normal_r[1] >= -18'sd65536;

  `RSI_ASSERT(a_miss_zero, out_valid_r && !out_hit_r |-> miss_payload_zero, "miss item with nonzero payload")
  `RSI_ASSERT(a_stall_holds_input, out_valid_r && out_stall |-> in_stall, "input taken while output item stalled")
  `RSI_ASSERT(a_normal_range, out_valid_r && out_hit_r |-> normal_in_range, "normal component out of range")

endmodule

// ===== rtl/rsi_sqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
`timescale 1ns / 1ps
module rsi_sqrt import rsi_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  rad,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_REM_W-1:0] rem_r  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_r [SQ_OUT_W];
  logic [SQ_IN_W-1:0]  rad_r  [SQ_OUT_W];

  for (genvar j = 0; j < SQ_OUT_W; j++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_in, rem_sh, trial, rem_nxt;
    logic [SQ_OUT_W-1:0] root_in, root_nxt;
    logic [SQ_IN_W-1:0]  rad_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    always_comb begin
      rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
      trial  = SQ_REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[SQ_OUT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        rad_r[j]  <= rad_in << 2;
      end
    end
  end

  assign root = root_r[SQ_OUT_W-1];

endmodule

// ===== rtl/rsi_div.sv =====
// Pipelined restoring divider for one normal component, one quotient bit per stage.
`timescale 1ns / 1ps
module rsi_div import rsi_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NA_W-1:0]   num,
  input  logic [LEN_W-1:0]  den,
  output logic [DV_Q_W-1:0] quo
);

  logic [DV_REM_W-1:0] rem_r [DV_Q_W];
  logic [DV_Q_W-1:0]   q_r   [DV_Q_W];
  logic [LEN_W-1:0]    den_r [DV_Q_W];

  for (genvar j = 0; j < DV_Q_W; j++) begin : g_stage
    logic [DV_REM_W-1:0] rem_in, rem_nxt;
    logic [DV_Q_W-1:0]   q_in, q_nxt;
    logic [LEN_W-1:0]    den_in;
    logic [DV_CMP_W-1:0] cmp;

    if (j == 0) begin : g_first
      assign rem_in = {num, FRAC_W'(0)};
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign den_in = den_r[j-1];
    end

    always_comb begin
      cmp = DV_CMP_W'(den_in) << (DV_Q_W - 1 - j);
      if (DV_CMP_W'(rem_in) >= cmp) begin
        rem_nxt = rem_in - cmp[DV_REM_W-1:0];
        q_nxt   = {q_in[DV_Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_in;
        q_nxt   = {q_in[DV_Q_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        den_r[j] <= den_in;
      end
    end
  end

  assign quo = q_r[DV_Q_W-1];

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ray/sphere intersection core.
`timescale 1ns / 1ps
module tb;
  import rsi_pkg::*;

  localparam longint ONE      = 65536;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam int     WD_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [17:0] dx, dy, dz;
    logic               sos;
  } ray_t;

  typedef struct {
    logic               hit;
    logic [30:0]        dst;
    logic signed [31:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
  } hit_t;

  typedef struct {
    ray_t r;
    bit   typed;
    hit_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [17:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic in_starts_on_sphere = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [30:0] out_distance;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;
  logic signed [17:0] out_normal_x, out_normal_y, out_normal_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_sphere_intersect_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sphere settings as the predictor sees them
  longint cen_x = 0, cen_y = 0, cen_z = 0, rad = ONE;

  hit_t   pending_hits[$];
  ray_t   cur_ray;
  bit     cur_typed = 0;
  hit_t   cur_exp;
  int     rays_taken = 0;
  int     results_seen = 0;
  int     hits_seen = 0;
  int     n_errors = 0;
  int     n_configs = 0;
  bit     hold_req = 0;
  int     idle_cycles = 0;

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] v);
    logic [127:0] r, c;
    int k;
    r = '0;
    for (k = 38; k >= 0; k--) begin
      c = r | (128'd1 << k);
      if (c * c <= v) r = c;
    end
    return r[63:0];
  endfunction

  function automatic hit_t trace_sphere(ray_t r);
    hit_t h;
    longint o[3], d[3], c[3], m[3], hp[3], nv;
    longint b, s, tn, tf, t;
    logic [127:0] mm, lhs, mu, l2;
    longint unsigned a[3], big, len, q;
    bit neg[3];
    int i;
    h = '{default: '0};
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    c[0] = cen_x; c[1] = cen_y; c[2] = cen_z;
    b = 0;
    mm = '0;
    for (i = 0; i < 3; i++) begin
      m[i] = o[i] - c[i];
      b += d[i] * m[i];
      mu = {64'd0, mag64(m[i])};
      mm = mm + mu * mu;
    end
    b = b >>> 16;
    mu = {64'd0, mag64(b)};
    lhs = mu * mu + {64'd0, rad} * {64'd0, rad};
    if (mm > lhs) return h;
    s = isqrt(lhs - mm);
    tn = -b - s;
    tf = -b + s;
    if (r.sos) begin
      if (mag64(tn) > mag64(tf)) return h;
      t = tf;
    end else begin
      t = (tn < 0) ? tf : tn;
    end
    if (t < 0) return h;
    h.hit = 1'b1;
    h.dst = (t > longint'(MAX_DIST)) ? MAX_DIST : t[30:0];
    big = 0;
    for (i = 0; i < 3; i++) begin
      hp[i] = o[i] + ((d[i] * t) >>> 16);
      nv = hp[i] - c[i];
      neg[i] = nv < 0;
      a[i] = mag64(nv);
      if (a[i] > big) big = a[i];
    end
    h.px = (hp[0] > S32_MAX) ? S32_MAX : (hp[0] < S32_MIN) ? S32_MIN : hp[0];
    h.py = (hp[1] > S32_MAX) ? S32_MAX : (hp[1] < S32_MIN) ? S32_MIN : hp[1];
    h.pz = (hp[2] > S32_MAX) ? S32_MAX : (hp[2] < S32_MIN) ? S32_MIN : hp[2];
    if (big == 0) return h;
    while (big >= (64'd1 << 30)) begin
      big >>= 1;
      for (i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      big <<= 1;
      for (i = 0; i < 3; i++) a[i] <<= 1;
    end
    l2 = '0;
    for (i = 0; i < 3; i++) l2 = l2 + {64'd0, a[i]} * {64'd0, a[i]};
    len = isqrt(l2);
    for (i = 0; i < 3; i++) begin
      q = (a[i] << 16) / len;
      if (q > ONE) q = ONE;
      nv = neg[i] ? -longint'(q) : longint'(q);
      if (i == 0) h.nx = nv[17:0];
      else if (i == 1) h.ny = nv[17:0];
      else h.nz = nv[17:0];
    end
    return h;
  endfunction

  // --- monitors ---
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_hits.push_back(cur_typed ? cur_exp : trace_sphere(cur_ray));
      rays_taken <= rays_taken + 1;
    end
  end

  task automatic field_chk(string nm, longint e, longint a);
    if (e != a) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch on result %0d, %s: expected %0d got %0d",
                 results_seen, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("result item with nothing expected");
      end else begin
        e = pending_hits.pop_front();
        field_chk("hit", e.hit, out_hit);
        field_chk("distance", e.dst, out_distance);
        field_chk("point_x", e.px, out_point_x);
        field_chk("point_y", e.py, out_point_y);
        field_chk("point_z", e.pz, out_point_z);
        field_chk("normal_x", e.nx, out_normal_x);
        field_chk("normal_y", e.ny, out_normal_y);
        field_chk("normal_z", e.nz, out_normal_z);
        if (out_hit) hits_seen++;
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)
        || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // --- receiver back-pressure ---
  initial begin
    int k, n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_req = 0;
        out_stall = 1'b0;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 65) begin
          out_stall = 1'b0;
          n = $urandom_range(1, 20);
        end else if (k < 95) begin
          out_stall = 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall = 1'b1;
          n = $urandom_range(15, 60);
        end
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // --- driving ---
  task automatic cfg_write(logic [1:0] code, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {code, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (code)
      REG_CENTER_X: cen_x = longint'(signed'(val));
      REG_CENTER_Y: cen_y = longint'(signed'(val));
      REG_CENTER_Z: cen_z = longint'(signed'(val));
      default:      rad = val[30:0];
    endcase
    n_configs++;
  endtask

  task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [30:0] r);
    cfg_write(REG_CENTER_X, x);
    cfg_write(REG_CENTER_Y, y);
    cfg_write(REG_CENTER_Z, z);
    cfg_write(REG_RADIUS, {1'b0, r});
  endtask

  task automatic send_ray(ray_t r, bit typed, hit_t e);
    int k, gap, n0;
    k = $urandom_range(0, 99);
    gap = (k < 75) ? 0 : (k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_ray = r; cur_typed = typed; cur_exp = e;
    in_origin_x = r.ox; in_origin_y = r.oy; in_origin_z = r.oz;
    in_dir_x = r.dx; in_dir_y = r.dy; in_dir_z = r.dz;
    in_starts_on_sphere = r.sos;
    in_valid = 1'b1;
    n0 = rays_taken;
    do @(negedge clk); while (rays_taken == n0);
  endtask

  function automatic ray_t mkray(longint ox, longint oy, longint oz,
                                 longint dx, longint dy, longint dz, bit sos);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    r.sos = sos;
    return r;
  endfunction

  function automatic logic signed [31:0] to_q32(real v);
    if (v > 2147483647.0) return 32'sh7fff_ffff;
    if (v < -2147483648.0) return 32'sh8000_0000;
    return longint'(v);
  endfunction

  function automatic real urand_unit();
    return (real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
  endfunction

  // mostly aimed rays and rays leaving the surface, the rest raw bits
  function automatic ray_t random_ray();
    ray_t r;
    real u[3], w[3], ln, rr, span;
    int i, k;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      r = mkray(longint'(signed'($urandom())), longint'(signed'($urandom())),
                longint'(signed'($urandom())),
                longint'(signed'(18'($urandom()))), longint'(signed'(18'($urandom()))),
                longint'(signed'(18'($urandom()))), $urandom_range(0, 1));
      return r;
    end
    rr = real'(rad);
    span = (rr < 65536.0) ? 262144.0 : 4.0 * rr;
    for (i = 0; i < 3; i++) u[i] = urand_unit();
    ln = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
    if (ln < 0.001) begin u[0] = 1.0; u[1] = 0.0; u[2] = 0.0; ln = 1.0; end
    for (i = 0; i < 3; i++) u[i] = u[i] / ln;
    if (k < 40) begin
      // origin on the surface
      r.ox = to_q32(real'(cen_x) + rr * u[0]);
      r.oy = to_q32(real'(cen_y) + rr * u[1]);
      r.oz = to_q32(real'(cen_z) + rr * u[2]);
      for (i = 0; i < 3; i++) w[i] = urand_unit();
      r.sos = 1'b1;
    end else begin
      r.ox = to_q32(real'(cen_x) + span * urand_unit());
      r.oy = to_q32(real'(cen_y) + span * urand_unit());
      r.oz = to_q32(real'(cen_z) + span * urand_unit());
      // aim at a point near the centre
      w[0] = real'(cen_x) + rr * 0.7 * u[0] - real'(r.ox);
      w[1] = real'(cen_y) + rr * 0.7 * u[1] - real'(r.oy);
      w[2] = real'(cen_z) + rr * 0.7 * u[2] - real'(r.oz);
      if ($urandom_range(0, 3) == 0) for (i = 0; i < 3; i++) w[i] = -w[i];
      r.sos = ($urandom_range(0, 9) == 0);
    end
    ln = $sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
    if (ln < 1.0e-9) begin w[0] = 0.0; w[1] = 0.0; w[2] = 1.0; ln = 1.0; end
    r.dx = longint'(65536.0 * w[0] / ln);
    r.dy = longint'(65536.0 * w[1] / ln);
    r.dz = longint'(65536.0 * w[2] / ln);
    return r;
  endfunction

  task automatic drain();
    in_valid = 1'b0;
    wait (pending_hits.size() == 0);
    @(negedge clk);
  endtask

  task automatic random_rays(int n, bit squeeze);
    int i;
    hit_t none;
    none = '{default: '0};
    for (i = 0; i < n; i++) begin
      if (squeeze && i == n / 2) hold_req = 1;
      send_ray(random_ray(), 1'b0, none);
    end
  endtask

  row_t   dir_rows[$];
  hit_t   miss_res, front_hit;

  initial begin
    int i;
    miss_res = '{default: '0};
    front_hit = '{1'b1, 31'd262144, 32'sd0, 32'sd0, -32'sd65536, 18'sd0, 18'sd0, -18'sd65536};
    // unit sphere at the origin
    dir_rows.push_back('{mkray(0, 0, -5 * ONE, 0, 0, ONE, 0), 1'b1, front_hit});
    dir_rows.push_back('{mkray(0, 0, -5 * ONE, 0, 0, -ONE, 0), 1'b1, miss_res});
    dir_rows.push_back('{mkray(0, 5 * ONE, -5 * ONE, 0, 0, ONE, 0), 1'b1, miss_res});
    dir_rows.push_back('{mkray(0, 0, 0, ONE, 0, 0, 0), 1'b0, miss_res});
    dir_rows.push_back('{mkray(0, 0, -ONE, 0, 0, ONE, 1), 1'b0, miss_res});
    dir_rows.push_back('{mkray(0, 0, -ONE, 0, 0, -ONE, 1), 1'b0, miss_res});
    dir_rows.push_back('{mkray(ONE, 0, 0, 0, ONE, 0, 1), 1'b0, miss_res});
    dir_rows.push_back('{mkray(0, 0, 0, 0, 0, 0, 0), 1'b0, miss_res});
    dir_rows.push_back('{mkray(ONE / 2, 0, 0, 0, 0, 0, 1), 1'b0, miss_res});
    dir_rows.push_back('{mkray(ONE, 0, -3 * ONE, 0, 0, ONE, 0), 1'b0, miss_res});
    dir_rows.push_back('{mkray(0, 0, 0, 46341, 46341, 0, 0), 1'b0, miss_res});
    dir_rows.push_back('{mkray(S32_MAX, S32_MAX, S32_MAX, 131071, 131071, 131071, 0),
                         1'b0, miss_res});
    dir_rows.push_back('{mkray(S32_MIN, S32_MIN, S32_MIN, -131072, -131072, -131072, 1),
                         1'b0, miss_res});
    dir_rows.push_back('{mkray(S32_MIN, S32_MAX, 0, 131071, -131072, 0, 0), 1'b0, miss_res});
    dir_rows.push_back('{mkray(-2 * ONE, 0, 0, ONE, 0, 0, 1), 1'b0, miss_res});
    dir_rows.push_back('{mkray(0, -4 * ONE, 0, 0, ONE, 0, 0), 1'b0, miss_res});

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (i = 0; i < dir_rows.size(); i++)
      send_ray(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
    random_rays(300, 1'b1);
    drain();

    set_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd0);
    random_rays(220, 1'b0);
    drain();
    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, MAX_DIST);
    random_rays(220, 1'b0);
    drain();
    set_sphere($urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000,
               $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000,
               $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000,
               $urandom_range(1, 32'h0100_0000));
    random_rays(220, 1'b0);
    drain();
    set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'h0004_0000));
    random_rays(220, 1'b0);
    drain();
    set_sphere(0, 0, 0, $urandom_range(32'h1000_0000, 32'h7fff_ffff));
    random_rays(220, 1'b0);
    drain();

    repeat (120) @(negedge clk);
    $display("%0d rays over %0d register writes, %0d results (%0d hits, %0d misses)",
             rays_taken, n_configs, results_seen, hits_seen, results_seen - hits_seen);
    if (n_errors == 0 && pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, pending_hits.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
